// ===== hdl/md5bc_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 block compression package
// Shared widths, payload and command types, and the MD5 step tables.
// ----------------------------------------------------------------------------
package md5bc_pkg;

    localparam int WORD_W    = 32;
    localparam int BLK_WORDS = 16;
    localparam int CNT_W     = 4;
    localparam int STEPS     = 64;
    localparam int STEP_W    = 6;
    localparam int RAM_DEPTH = 2 * BLK_WORDS;
    localparam int RAM_AW    = 5;
    localparam int IDX_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int ROT_W     = 5;

    localparam logic [CFG_IDX_W-1:0] CFG_INIT_A = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_B = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_C = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_D = 2'd3;

    localparam logic [IDX_W-1:0]  LAST_IDX  = 2'd3;
    localparam logic [STEP_W-1:0] LAST_STEP = 6'd63;
    localparam logic [CNT_W-1:0]  LAST_WORD = 4'd15;

    localparam logic [WORD_W-1:0] INIT_RST_A = 32'h6745_2301;
    localparam logic [WORD_W-1:0] INIT_RST_B = 32'hefcd_ab89;
    localparam logic [WORD_W-1:0] INIT_RST_C = 32'h98ba_dcfe;
    localparam logic [WORD_W-1:0] INIT_RST_D = 32'h1032_5476;

    typedef struct packed {
        logic [WORD_W-1:0] message_word;
        logic              start_message;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] digest_word;
        logic [IDX_W-1:0]  digest_index;
        logic              last_of_run;
    } t_out_item;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_ROUND,
        ST_ADD,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic              wr_en;
        logic [RAM_AW-1:0] wr_addr;
        logic [RAM_AW-1:0] rd_addr;
        logic              load_init;
        logic              prep;
        logic              round_en;
        logic [STEP_W-1:0] step;
        logic [STEP_W-1:0] k_step;
        logic              add;
        logic [IDX_W-1:0]  out_idx;
    } t_ctrl_cmd;

    localparam logic [WORD_W-1:0] SINE_K [STEPS] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam logic [ROT_W-1:0] ROT_AMT [16] = '{
        5'd7, 5'd12, 5'd17, 5'd22,
        5'd5, 5'd9,  5'd14, 5'd20,
        5'd4, 5'd11, 5'd16, 5'd23,
        5'd6, 5'd10, 5'd15, 5'd21
    };

    function automatic logic [CNT_W-1:0] msg_index(input logic [STEP_W-1:0] step);
        logic [CNT_W-1:0] s;
        logic [CNT_W-1:0] g;
        begin
            s = step[CNT_W-1:0];
            case (step[STEP_W-1:STEP_W-2])
                2'd0:    g = s;
                2'd1:    g = CNT_W'(s * 4'd5 + 4'd1);
                2'd2:    g = CNT_W'(s * 4'd3 + 4'd5);
                default: g = CNT_W'(s * 4'd7);
            endcase
            return g;
        end
    endfunction

endpackage

// ===== hdl/md5bc_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module md5bc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== hdl/md5bc_ctrl.sv =====
// ----------------------------------------------------------------------------
// MD5 block compression controller
// Tracks word intake into two buffer banks and sequences the 64 steps,
// the chaining update and the four digest outputs.
// ----------------------------------------------------------------------------
module md5bc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  logic                 i_start,
    output logic                 o_in_ready,
    input  logic                 i_out_ready,
    output logic                 o_out_valid,
    output md5bc_pkg::t_ctrl_cmd o_cmd
);

    md5bc_pkg::t_state r_state, n_state;

    logic [md5bc_pkg::STEP_W-1:0] r_step, n_step;
    logic [md5bc_pkg::IDX_W-1:0]  r_out_idx, n_out_idx;
    logic [md5bc_pkg::CNT_W-1:0]  r_count, n_count;
    logic                         r_wbank, n_wbank;
    logic                         r_cbank, n_cbank;
    logic                         r_blk_pend, n_blk_pend;
    logic                         r_load_pend, n_load_pend;

    logic                         in_acc;
    logic                         busy;
    logic                         blk_done;
    logic                         out_done;
    logic                         start_now;
    logic [md5bc_pkg::CNT_W-1:0]  eff_count;
    logic [md5bc_pkg::STEP_W-1:0] rd_step;

    assign in_acc    = i_in_valid & o_in_ready;
    assign busy      = (r_state != md5bc_pkg::ST_IDLE);
    assign eff_count = i_start ? '0 : r_count;
    assign blk_done  = in_acc & (eff_count == md5bc_pkg::LAST_WORD);
    assign out_done  = (r_state == md5bc_pkg::ST_OUT) & i_out_ready
                     & (r_out_idx == md5bc_pkg::LAST_IDX);
    assign start_now = (r_state == md5bc_pkg::ST_IDLE) & (blk_done | r_blk_pend);
    assign rd_step   = (r_state == md5bc_pkg::ST_PREP) ? '0
                     : md5bc_pkg::STEP_W'(r_step + 1'b1);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            md5bc_pkg::ST_IDLE: begin
                if (start_now) begin
                    n_state = md5bc_pkg::ST_PREP;
                end
            end
            md5bc_pkg::ST_PREP: begin
                n_state = md5bc_pkg::ST_ROUND;
            end
            md5bc_pkg::ST_ROUND: begin
                if (r_step == md5bc_pkg::LAST_STEP) begin
                    n_state = md5bc_pkg::ST_ADD;
                end
            end
            md5bc_pkg::ST_ADD: begin
                n_state = md5bc_pkg::ST_OUT;
            end
            md5bc_pkg::ST_OUT: begin
                if (out_done) begin
                    n_state = md5bc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = md5bc_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready        = ~r_blk_pend;
        o_out_valid       = (r_state == md5bc_pkg::ST_OUT);
        o_cmd.wr_en       = in_acc;
        o_cmd.wr_addr     = {r_wbank, eff_count};
        o_cmd.rd_addr     = {r_cbank, md5bc_pkg::msg_index(rd_step)};
        o_cmd.load_init   = (in_acc & i_start & (~busy | out_done))
                          | (r_load_pend & out_done);
        o_cmd.prep        = (r_state == md5bc_pkg::ST_PREP);
        o_cmd.round_en    = (r_state == md5bc_pkg::ST_ROUND);
        o_cmd.step        = r_step;
        o_cmd.k_step      = rd_step;
        o_cmd.add         = (r_state == md5bc_pkg::ST_ADD);
        o_cmd.out_idx     = r_out_idx;
    end

    always_comb begin
        n_count     = in_acc ? md5bc_pkg::CNT_W'(eff_count + 1'b1) : r_count;
        n_wbank     = blk_done ? ~r_wbank : r_wbank;
        n_cbank     = r_cbank;
        n_blk_pend  = r_blk_pend;
        n_load_pend = (r_load_pend | (in_acc & i_start & busy)) & ~out_done;
        n_step      = r_step;
        n_out_idx   = r_out_idx;
        if (start_now) begin
            n_cbank    = r_blk_pend ? ~r_wbank : r_wbank;
            n_blk_pend = 1'b0;
        end else if (blk_done & busy) begin
            n_blk_pend = 1'b1;
        end
        if (r_state == md5bc_pkg::ST_ROUND) begin
            n_step = md5bc_pkg::STEP_W'(r_step + 1'b1);
        end else if (r_state == md5bc_pkg::ST_PREP) begin
            n_step = '0;
        end
        if (o_out_valid & i_out_ready) begin
            n_out_idx = md5bc_pkg::IDX_W'(r_out_idx + 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= md5bc_pkg::ST_IDLE;
            r_step      <= '0;
            r_out_idx   <= '0;
            r_count     <= '0;
            r_wbank     <= 1'b0;
            r_cbank     <= 1'b0;
            r_blk_pend  <= 1'b0;
            r_load_pend <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_step      <= n_step;
            r_out_idx   <= n_out_idx;
            r_count     <= n_count;
            r_wbank     <= n_wbank;
            r_cbank     <= n_cbank;
            r_blk_pend  <= n_blk_pend;
            r_load_pend <= n_load_pend;
        end
    end

endmodule

// ===== hdl/md5bc_dp.sv =====
// ----------------------------------------------------------------------------
// MD5 block compression datapath
// Initial-word registers, chaining value, working registers, the block
// buffer and the single-step MD5 round logic.
// ----------------------------------------------------------------------------
module md5bc_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [md5bc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [md5bc_pkg::WORD_W-1:0]        i_cfg_data,
    input  md5bc_pkg::t_ctrl_cmd                i_cmd,
    input  logic [md5bc_pkg::WORD_W-1:0]        i_word,
    output logic [md5bc_pkg::WORD_W-1:0]        o_digest_word
);

    logic [md5bc_pkg::WORD_W-1:0] r_init [4];
    logic [md5bc_pkg::WORD_W-1:0] r_cv [4];
    logic [md5bc_pkg::WORD_W-1:0] r_a, r_b, r_c, r_d, r_pre;

    logic [md5bc_pkg::WORD_W-1:0]   rd_data;
    logic [md5bc_pkg::WORD_W-1:0]   f_val;
    logic [md5bc_pkg::WORD_W-1:0]   sum;
    logic [2*md5bc_pkg::WORD_W-1:0] dbl;
    logic [md5bc_pkg::WORD_W-1:0]   n_b;
    logic [md5bc_pkg::ROT_W-1:0]    rot;

    md5bc_ram #(
        .WIDTH (md5bc_pkg::WORD_W),
        .DEPTH (md5bc_pkg::RAM_DEPTH)
    ) u_buf (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr_en),
        .i_wr_addr (i_cmd.wr_addr),
        .i_wr_data (i_word),
        .i_rd_addr (i_cmd.rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        unique case (i_cmd.step[md5bc_pkg::STEP_W-1:md5bc_pkg::STEP_W-2])
            2'd0:    f_val = (r_b & r_c) | (~r_b & r_d);
            2'd1:    f_val = (r_d & r_b) | (~r_d & r_c);
            2'd2:    f_val = r_b ^ r_c ^ r_d;
            default: f_val = r_c ^ (r_b | ~r_d);
        endcase
        rot   = md5bc_pkg::ROT_AMT[{i_cmd.step[md5bc_pkg::STEP_W-1:md5bc_pkg::STEP_W-2],
                                    i_cmd.step[1:0]}];
        sum   = r_pre + f_val + rd_data;
        dbl   = {sum, sum} << rot;
        n_b   = r_b + dbl[2*md5bc_pkg::WORD_W-1:md5bc_pkg::WORD_W];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init[0] <= md5bc_pkg::INIT_RST_A;
            r_init[1] <= md5bc_pkg::INIT_RST_B;
            r_init[2] <= md5bc_pkg::INIT_RST_C;
            r_init[3] <= md5bc_pkg::INIT_RST_D;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                md5bc_pkg::CFG_INIT_A: r_init[0] <= i_cfg_data;
                md5bc_pkg::CFG_INIT_B: r_init[1] <= i_cfg_data;
                md5bc_pkg::CFG_INIT_C: r_init[2] <= i_cfg_data;
                md5bc_pkg::CFG_INIT_D: r_init[3] <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= md5bc_pkg::INIT_RST_A;
            r_cv[1] <= md5bc_pkg::INIT_RST_B;
            r_cv[2] <= md5bc_pkg::INIT_RST_C;
            r_cv[3] <= md5bc_pkg::INIT_RST_D;
        end else if (i_cmd.load_init) begin
            r_cv <= r_init;
        end else if (i_cmd.add) begin
            r_cv[0] <= r_cv[0] + r_a;
            r_cv[1] <= r_cv[1] + r_b;
            r_cv[2] <= r_cv[2] + r_c;
            r_cv[3] <= r_cv[3] + r_d;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.prep) begin
            r_a   <= r_cv[0];
            r_b   <= r_cv[1];
            r_c   <= r_cv[2];
            r_d   <= r_cv[3];
            r_pre <= r_cv[0] + md5bc_pkg::SINE_K[i_cmd.k_step];
        end else if (i_cmd.round_en) begin
            r_a   <= r_d;
            r_b   <= n_b;
            r_c   <= r_b;
            r_d   <= r_c;
            r_pre <= r_d + md5bc_pkg::SINE_K[i_cmd.k_step];
        end
    end

    assign o_digest_word = r_cv[i_cmd.out_idx];

endmodule

// ===== hdl/md5_block_compression.sv =====
// ----------------------------------------------------------------------------
// MD5 block compression
// Compresses padded 16-word blocks into the chaining value and emits the
// four updated chaining words per block.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake                   Payload
//  in       in         i_in_valid / o_in_ready     i_in  (message word, start)
//  out      out        o_out_valid / i_out_ready   o_out (digest word, index, last)
//  cfg      in         i_cfg_valid / o_cfg_ready   i_cfg_index, i_cfg_data
//
//  Words are taken one per cycle while o_in_ready is high, into one of two
//  buffer banks, also while the previous block is compressed.
//  Compression runs one MD5 step per cycle: a setup, the 64 steps, the
//  chaining update, then the four results, which wait on i_out_ready.
//  A start flag taken during compression reloads the chaining value once the
//  running block's results are delivered; a second full block stalls intake.
//  Reset is synchronous and needs no clearing pass.
// ----------------------------------------------------------------------------
module md5_block_compression (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  md5bc_pkg::t_in_item             i_in,
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output md5bc_pkg::t_out_item            o_out,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [md5bc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [md5bc_pkg::WORD_W-1:0]    i_cfg_data
);

    md5bc_pkg::t_ctrl_cmd         cmd;
    logic [md5bc_pkg::WORD_W-1:0] digest_word;

    assign o_cfg_ready = 1'b1;

    md5bc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_start     (i_in.start_message),
        .o_in_ready  (o_in_ready),
        .i_out_ready (i_out_ready),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    md5bc_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_valid & o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_cmd         (cmd),
        .i_word        (i_in.message_word),
        .o_digest_word (digest_word)
    );

    always_comb begin
        o_out.digest_word  = digest_word;
        o_out.digest_index = cmd.out_idx;
        o_out.last_of_run  = (cmd.out_idx == md5bc_pkg::LAST_IDX);
    end

endmodule

// ===== hdl/md5bc_chk.sv =====
// ----------------------------------------------------------------------------
// MD5 block compression checker
// Port-level assertions on the result sequence, bound to the top level.
// ----------------------------------------------------------------------------
module md5bc_chk (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input md5bc_pkg::t_out_item o_out
);

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("result shown right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out))
        else $error("stalled result changed or dropped");

    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && !o_out.last_of_run |=>
            o_out_valid && (o_out.digest_index == $past(o_out.digest_index) + 2'd1))
        else $error("digest words out of order");

    a_last_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out.last_of_run == (o_out.digest_index == md5bc_pkg::LAST_IDX)))
        else $error("last mark on wrong digest word");

    a_run_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_ready && o_out.last_of_run |=> !o_out_valid)
        else $error("new run started without compression");

endmodule

bind md5_block_compression md5bc_chk u_md5bc_chk (.*);

// ===== dv/tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// MD5 block compression testbench
// Feeds message words through the valid/ready request channel and
// programs the initial chaining words over the configuration channel. A
// behavioral MD5 compression model predicts the four digest words of every
// completed block, and each returned digest word is compared field by field in
// arrival order. Directed blocks cover extreme words, the reset chaining
// value, a restart in the middle of a block and the deferred effect of
// register writes. Random traffic follows under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb;

    localparam int DRAIN_CYCLES = 5000;
    localparam int PAUSE_CYCLES = 100;
    localparam longint LIMIT_NS = 2_000_000;

    localparam logic [md5bc_pkg::WORD_W-1:0] MIX_CONST [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int unsigned SHIFT_TBL [16] = '{
        7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21
    };

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_in_valid = 1'b0;
    logic                            o_in_ready;
    md5bc_pkg::t_in_item             i_in = '0;
    logic                            o_out_valid;
    logic                            i_out_ready = 1'b0;
    md5bc_pkg::t_out_item            o_out;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [md5bc_pkg::CFG_IDX_W-1:0] i_cfg_index = md5bc_pkg::CFG_INIT_A;
    logic [md5bc_pkg::WORD_W-1:0]    i_cfg_data = '0;

    logic [md5bc_pkg::WORD_W-1:0] init_words [4] = '{
        md5bc_pkg::INIT_RST_A, md5bc_pkg::INIT_RST_B,
        md5bc_pkg::INIT_RST_C, md5bc_pkg::INIT_RST_D
    };
    logic [md5bc_pkg::WORD_W-1:0] chain_words [4] = '{
        md5bc_pkg::INIT_RST_A, md5bc_pkg::INIT_RST_B,
        md5bc_pkg::INIT_RST_C, md5bc_pkg::INIT_RST_D
    };
    logic [md5bc_pkg::WORD_W-1:0] block_words [16];
    int                           block_fill = 0;
    md5bc_pkg::t_out_item         digest_q [$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int error_count = 0;

    md5_block_compression DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    task automatic report_mismatch(input string what,
                                   input logic [md5bc_pkg::WORD_W-1:0] got,
                                   input logic [md5bc_pkg::WORD_W-1:0] want);
        $display("%0t ns: mismatch in %s: got %h, expected %h", $time, what, got, want);
        error_count++;
    endtask

    function automatic void compress_into_chain();
        logic [md5bc_pkg::WORD_W-1:0] a, b, c, d, f, t;
        int unsigned                  g, sh, step;
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        for (step = 0; step < 64; step++) begin
            case (step / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = step;
                end
                1: begin
                    f = (d & b) | (~d & c);
                    g = 5 * step + 1;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = 3 * step + 5;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = 7 * step;
                end
            endcase
            t = a + f + MIX_CONST[step] + block_words[g % 16];
            sh = SHIFT_TBL[(step / 16) * 4 + step % 4];
            a = d;
            d = c;
            c = b;
            b = b + ((t << sh) | (t >> (32 - sh)));
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
    endfunction

    function automatic void absorb_word(input md5bc_pkg::t_in_item req);
        md5bc_pkg::t_out_item digest;
        int                   k;
        if (req.start_message) begin
            chain_words = init_words;
            block_fill = 0;
        end
        block_words[block_fill] = req.message_word;
        block_fill++;
        if (block_fill == 16) begin
            block_fill = 0;
            compress_into_chain();
            for (k = 0; k < 4; k++) begin
                digest.digest_word = chain_words[k];
                digest.digest_index = md5bc_pkg::IDX_W'(k);
                digest.last_of_run = (md5bc_pkg::IDX_W'(k) == md5bc_pkg::LAST_IDX);
                digest_q.push_back(digest);
            end
        end
    endfunction

    function automatic logic [md5bc_pkg::WORD_W-1:0] pick_word();
        logic [md5bc_pkg::WORD_W-1:0] one_hot;
        one_hot = md5bc_pkg::WORD_W'(1) << $urandom_range(md5bc_pkg::WORD_W - 1);
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            2: return one_hot;
            3: return ~one_hot;
            default: return $urandom;
        endcase
    endfunction

    task automatic send_word(input logic [md5bc_pkg::WORD_W-1:0] word, input logic start);
        md5bc_pkg::t_in_item req;
        req.message_word = word;
        req.start_message = start;
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in <= req;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        absorb_word(req);
    endtask

    task automatic write_init_words(input logic [md5bc_pkg::WORD_W-1:0] wa, wb, wc, wd);
        logic [md5bc_pkg::WORD_W-1:0]    vals [4];
        logic [md5bc_pkg::CFG_IDX_W-1:0] regs [4];
        int                              n;
        vals = '{wa, wb, wc, wd};
        regs = '{md5bc_pkg::CFG_INIT_A, md5bc_pkg::CFG_INIT_B,
                 md5bc_pkg::CFG_INIT_C, md5bc_pkg::CFG_INIT_D};
        for (n = 0; n < 4; n++) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= regs[n];
            i_cfg_data <= vals[n];
            do @(posedge i_clk); while (o_cfg_ready !== 1'b1);
            init_words[regs[n]] = vals[n];
        end
        i_cfg_valid <= 1'b0;
    endtask

    task automatic settle();
        md5bc_pkg::t_out_item left;
        int                   n;
        i_in_valid <= 1'b0;
        n = 0;
        while (digest_q.size() != 0 && n < DRAIN_CYCLES) begin
            @(posedge i_clk);
            n++;
        end
        while (digest_q.size() != 0) begin
            left = digest_q.pop_front();
            report_mismatch("missing digest word", 'x, left.digest_word);
        end
        repeat (PAUSE_CYCLES) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        md5bc_pkg::t_out_item want;
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (digest_q.size() == 0) begin
                report_mismatch("unexpected digest word", o_out.digest_word, 'x);
            end else begin
                want = digest_q.pop_front();
                if (o_out.digest_word !== want.digest_word)
                    report_mismatch("digest_word", o_out.digest_word, want.digest_word);
                if (o_out.digest_index !== want.digest_index)
                    report_mismatch("digest_index",
                                    md5bc_pkg::WORD_W'(o_out.digest_index),
                                    md5bc_pkg::WORD_W'(want.digest_index));
                if (o_out.last_of_run !== want.last_of_run)
                    report_mismatch("last_of_run",
                                    md5bc_pkg::WORD_W'(o_out.last_of_run),
                                    md5bc_pkg::WORD_W'(want.last_of_run));
            end
        end
        i_out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // A block with no start flag right after reset hashes from the reset chaining value.
    task automatic test_reset_chain();
        logic [md5bc_pkg::WORD_W-1:0] words [16];
        int                           k;
        words = '{32'h0000_0000, 32'hffff_ffff, 32'h8000_0000, 32'h0000_0001,
                  32'h7fff_ffff, 32'hffff_fffe, 32'haaaa_aaaa, 32'h5555_5555,
                  32'h0000_0080, 32'hffff_ffff, 32'h0000_0000, 32'h8000_0001,
                  32'hffff_ffff, 32'h0000_0000, 32'h0000_0018, 32'hffff_ffff};
        for (k = 0; k < 16; k++)
            send_word(words[k], 1'b0);
    endtask

    // A start flag in the middle of a block drops the partial block.
    task automatic test_restart_mid_block();
        int k;
        for (k = 0; k < 3; k++)
            send_word(pick_word(), k == 0);
        for (k = 0; k < 16; k++) begin
            case (k)
                0: send_word(32'h8063_6261, 1'b1);
                14: send_word(32'h0000_0018, 1'b0);
                default: send_word('0, 1'b0);
            endcase
        end
    endtask

    // New initial words leave the running chain alone until the next start flag.
    task automatic test_init_words_on_start();
        int k;
        settle();
        write_init_words($urandom, $urandom, $urandom, $urandom);
        for (k = 0; k < 16; k++)
            send_word(pick_word(), 1'b0);
        for (k = 0; k < 16; k++)
            send_word(pick_word(), k == 0);
    endtask

    task automatic test_random_traffic(input logic [md5bc_pkg::WORD_W-1:0] wa, wb, wc, wd,
                                       input int idle_pct, stall_pct, n_items);
        int sent;
        int roll;
        int len;
        int k;
        settle();
        write_init_words(wa, wb, wc, wd);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        sent = 0;
        while (sent < n_items) begin
            roll = $urandom_range(99);
            if (roll < 10) begin
                len = $urandom_range(1, 15);
                for (k = 0; k < len; k++)
                    send_word(pick_word(), k == 0 && $urandom_range(1));
            end else if (roll < 16) begin
                len = $urandom_range(1, 20);
                for (k = 0; k < len; k++)
                    send_word(pick_word(), $urandom_range(7) == 0);
            end else begin
                len = 16 * $urandom_range(1, 3);
                for (k = 0; k < len; k++)
                    send_word(pick_word(), k == 0 && $urandom_range(9) != 0);
            end
            sent += len;
        end
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_reset_chain();
        test_restart_mid_block();
        test_init_words_on_start();
        test_random_traffic('0, '0, '0, '0, 0, 0, 110);
        test_random_traffic('1, '1, '1, '1, 71, 0, 110);
        test_random_traffic($urandom, $urandom, $urandom, $urandom, 0, 71, 110);
        test_random_traffic(md5bc_pkg::INIT_RST_A, md5bc_pkg::INIT_RST_B,
                            md5bc_pkg::INIT_RST_C, md5bc_pkg::INIT_RST_D, 33, 33, 110);
        settle();
        if (error_count == 0) begin
            $display("** md5_block_compression: PASSED **");
        end else begin
            $display("** md5_block_compression: FAILED **");
        end
        $finish;
    end

    initial begin
        #(LIMIT_NS);
        $display("** md5_block_compression: FAILED **");
        $finish;
    end

endmodule
